>>> sv/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg - shared types and constants for the polyline area and length block
// Widths of the vertex path, the job that goes from the front end to the
// back end, and the saturating area accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

    // fixed configuration
    localparam int COORD_BITS       = 16;
    localparam int MAX_POINTS       = 1024;
    localparam int LENGTH_FRAC_BITS = 4;
    localparam int QUEUE_DEPTH      = 2;     // power of two

    // derived widths
    localparam int CNT_W     = 11;                       // point count port
    localparam int OP_W      = COORD_BITS + 1;           // sums and differences
    localparam int PROD_W    = 2 * OP_W;                 // one product
    localparam int ITERS     = OP_W + LENGTH_FRAC_BITS;  // root bits
    localparam int RAD_W     = 2 * ITERS;                // scaled radicand
    localparam int REM_W     = ITERS + 2;                // partial remainder
    localparam int ITER_W    = $clog2(ITERS);
    localparam int AREA_W    = 50;                       // twice the signed area
    localparam int AREA_OUT_W = 48;
    localparam int LEN_W     = 32;
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    // one classified vertex, ready for the arithmetic
    typedef struct packed {
        logic signed [OP_W-1:0] sx;     // x_prev + x
        logic signed [OP_W-1:0] dyn;    // y_prev - y
        logic signed [OP_W-1:0] dx;     // x - x_prev
        logic signed [OP_W-1:0] csx;    // x + x_first
        logic signed [OP_W-1:0] cdy;    // y - y_first
        logic                   seg;    // a segment ends at this vertex
        logic                   last;   // closes the path
        logic [CNT_W-1:0]       count;  // vertices so far, saturated
    } t_job;

    // add one product into the area sum, clamped to the signed range
    function automatic logic signed [AREA_W-1:0] area_add(
        input logic signed [AREA_W-1:0] acc,
        input logic signed [PROD_W-1:0] term
    );
        logic signed [AREA_W:0] s;
        s = {acc[AREA_W-1], acc} + {{(AREA_W + 1 - PROD_W){term[PROD_W-1]}}, term};
        if (s[AREA_W] != s[AREA_W-1]) begin
            area_add = s[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}} : {1'b0, {(AREA_W-1){1'b1}}};
        end else begin
            area_add = s[AREA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/pal_front.sv
// ----------------------------------------------------------------------------
// pal_front - vertex front end
// Accepts vertex beats, tracks first and previous vertex and the point
// count, and turns each vertex into a job of sums and differences.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_front
    import pal_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output      logic                         o_stall,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic                         i_last,
    input  wire logic                         i_q_full,
    output      logic                         o_push,
    output      t_job                         o_job
);

    logic signed [COORD_BITS-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic signed [OP_W-1:0]       x_e, y_e, px_e, py_e, fx_e, fy_e;
    logic                         first_pt;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // classify the vertex
    always_comb begin
        first_pt = (r_count == '0);
        x_e  = {i_x[COORD_BITS-1], i_x};
        y_e  = {i_y[COORD_BITS-1], i_y};
        px_e = {r_prev_x[COORD_BITS-1], r_prev_x};
        py_e = {r_prev_y[COORD_BITS-1], r_prev_y};
        fx_e = first_pt ? x_e : {r_first_x[COORD_BITS-1], r_first_x};
        fy_e = first_pt ? y_e : {r_first_y[COORD_BITS-1], r_first_y};
        n_count = (r_count < CNT_W'(MAX_POINTS)) ? r_count + 1'b1 : r_count;

        o_job.sx    = px_e + x_e;
        o_job.dyn   = py_e - y_e;
        o_job.dx    = x_e - px_e;
        o_job.csx   = x_e + fx_e;
        o_job.cdy   = y_e - fy_e;
        o_job.seg   = !first_pt;
        o_job.last  = i_last;
        o_job.count = n_count;
    end

    // path state, cleared after the closing vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_count   <= '0;
        end else if (o_push) begin
            if (i_last) begin
                r_first_x <= '0;
                r_first_y <= '0;
                r_prev_x  <= '0;
                r_prev_y  <= '0;
                r_count   <= '0;
            end else begin
                if (first_pt) begin
                    r_first_x <= i_x;
                    r_first_y <= i_y;
                end
                r_prev_x <= i_x;
                r_prev_y <= i_y;
                r_count  <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/pal_queue.sv
// ----------------------------------------------------------------------------
// pal_queue - job queue
// Short register queue that lets the front end keep taking vertices while
// the back end works on an earlier one.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_queue
    import pal_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output      logic o_full,
    input  wire logic i_pop,
    output      logic o_valid,
    output      t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/pal_back.sv
// ----------------------------------------------------------------------------
// pal_back - arithmetic back end
// Runs each job through one shared multiplier and a bit-serial square root,
// keeps the saturating area and length sums and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_back
    import pal_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire t_job                  i_q_job,
    output      logic                  o_pop,
    output      logic                  o_valid,
    input  wire logic                  i_stall,
    output      logic [AREA_OUT_W-1:0] o_area_q1,
    output      logic [LEN_W-1:0]      o_length_q4,
    output      logic [CNT_W-1:0]      o_point_count
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_AREA, S_MUL_DX, S_MUL_DY, S_SUM_D2,
        S_ROOT, S_ACC_LEN, S_MUL_CLOSE, S_ACC_CLOSE, S_EMIT
    } t_state;

    t_state                    r_state;
    t_job                      r_job;
    logic signed [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]         r_d2;
    logic [RAD_W-1:0]          r_rad;
    logic [REM_W-1:0]          r_rem;
    logic [ITERS-1:0]          r_root;
    logic [ITER_W-1:0]         r_iter;
    logic signed [AREA_W-1:0]  r_area;
    logic [LEN_W-1:0]          r_len;

    logic signed [OP_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         d2_sum;
    logic [REM_W-1:0]          rem_sh, trial, n_rem;
    logic [ITERS-1:0]          n_root;
    logic [LEN_W:0]            len_sum;
    logic [AREA_W-1:0]         area_mag;
    logic [AREA_OUT_W-1:0]     area_out;
    logic                      out_free;

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !o_valid || !i_stall;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MUL_AREA: begin
                mul_a = r_job.sx;
                mul_b = r_job.dyn;
            end
            S_MUL_DX: begin
                mul_a = r_job.dx;
                mul_b = r_job.dx;
            end
            S_MUL_DY: begin
                mul_a = r_job.dyn;
                mul_b = r_job.dyn;
            end
            S_MUL_CLOSE: begin
                mul_a = r_job.csx;
                mul_b = r_job.cdy;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // one square root step, segment sum and result saturation
    always_comb begin
        d2_sum  = r_d2 + $unsigned(r_prod);
        rem_sh  = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial   = {r_root, 2'b01};
        if (rem_sh >= trial) begin
            n_rem  = rem_sh - trial;
            n_root = {r_root[ITERS-2:0], 1'b1};
        end else begin
            n_rem  = rem_sh;
            n_root = {r_root[ITERS-2:0], 1'b0};
        end
        len_sum  = {1'b0, r_len} + {{(LEN_W + 1 - ITERS){1'b0}}, r_root};
        area_mag = r_area[AREA_W-1] ? $unsigned(-r_area) : $unsigned(r_area);
        area_out = (|area_mag[AREA_W-1:AREA_OUT_W]) ? '1 : area_mag[AREA_OUT_W-1:0];
    end

    // sequencer, accumulators and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_area  <= '0;
            r_len   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_prod <= prod;
            // result beat valid flag
            if ((r_state == S_EMIT) && out_free) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_job <= i_q_job;
                        if (i_q_job.seg) begin
                            r_state <= S_MUL_AREA;
                        end else if (i_q_job.last) begin
                            r_state <= S_MUL_CLOSE;
                        end
                    end
                end
                S_MUL_AREA: begin
                    r_state <= S_MUL_DX;
                end
                S_MUL_DX: begin
                    r_area  <= area_add(r_area, r_prod);
                    r_state <= S_MUL_DY;
                end
                S_MUL_DY: begin
                    r_d2    <= $unsigned(r_prod);
                    r_state <= S_SUM_D2;
                end
                S_SUM_D2: begin
                    r_rad   <= RAD_W'(d2_sum) << (2 * LENGTH_FRAC_BITS);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_iter  <= ITER_W'(ITERS - 1);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_iter <= r_iter - 1'b1;
                    if (r_iter == '0) begin
                        r_state <= S_ACC_LEN;
                    end
                end
                S_ACC_LEN: begin
                    r_len   <= len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
                    r_state <= r_job.last ? S_MUL_CLOSE : S_IDLE;
                end
                S_MUL_CLOSE: begin
                    r_state <= S_ACC_CLOSE;
                end
                S_ACC_CLOSE: begin
                    r_area  <= area_add(r_area, r_prod);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_area_q1     <= area_out;
                        o_length_q4   <= r_len;
                        o_point_count <= r_job.count;
                        r_area        <= '0;
                        r_len         <= '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/polyline_area_and_length.sv
// ----------------------------------------------------------------------------
// polyline_area_and_length - streaming shoelace area and polyline length
// Input channel: one vertex (x, y, last) per beat on i_valid / o_stall.
// Output channel: one beat per path (area, length, count) on o_valid / i_stall.
//
// A vertex with a preceding vertex makes three multiplier passes in the back end
// on a shared 17x17 multiplier, then a square root that produces one of its
// 21 result bits per cycle. The closing vertex adds the closing product and
// the result load.
// A two-entry job queue sits between the front end and the back end, so the
// front end takes vertices while the back end is busy; o_stall rises only
// when that queue is full.
// Reset clears the path state, both sums, the queue and the output register.
// When the receiver holds i_stall, the result stays in the output register
// and the back end waits before loading the next result; the queue then
// fills and o_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_area_and_length
    import pal_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output      logic                         o_stall,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic                         i_last,
    output      logic                         o_valid,
    input  wire logic                         i_stall,
    output      logic [AREA_OUT_W-1:0]        o_area_q1,
    output      logic [LEN_W-1:0]             o_length_q4,
    output      logic [CNT_W-1:0]             o_point_count
);

    t_job push_job, pop_job;
    logic push, pop, q_full, q_valid;

    // vertex classification
    pal_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_x      (i_x),
        .i_y      (i_y),
        .i_last   (i_last),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    // decoupling queue
    pal_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    // arithmetic and result register
    pal_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_job       (pop_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_area_q1     (o_area_q1),
        .o_length_q4   (o_length_q4),
        .o_point_count (o_point_count)
    );

endmodule

`default_nettype wire

>>> sv/pal_check.sv
// ----------------------------------------------------------------------------
// pal_check - port level checks for polyline_area_and_length
// Watches the result channel for reset behavior, held results and the
// degenerate one- and two-point paths.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_check
    import pal_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [AREA_OUT_W-1:0] o_area_q1,
    input wire logic [LEN_W-1:0]      o_length_q4,
    input wire logic [CNT_W-1:0]      o_point_count
);

    // a stalled result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_area_q1)
            && $stable(o_length_q4) && $stable(o_point_count))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // point count is within one and the saturation limit
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_point_count != '0 && o_point_count <= CNT_W'(MAX_POINTS))
        else $error("point count out of range");

    // a single point encloses nothing and has no length
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point_count == CNT_W'(1) |-> o_area_q1 == '0 && o_length_q4 == '0)
        else $error("single point path gave nonzero result");

    // out and back along one segment cancels in the area sum
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point_count == CNT_W'(2) |-> o_area_q1 == '0)
        else $error("two point path gave nonzero area");

endmodule

bind polyline_area_and_length pal_check u_pal_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_area_q1     (o_area_q1),
    .o_length_q4   (o_length_q4),
    .o_point_count (o_point_count)
);

`default_nettype wire

>>> tb/sv/polyline_area_and_length_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_area_and_length_test - self-checking bench for the path measurer
// A queue of vertex beats is built up front: a few hand-picked paths, one
// long back-and-forth path that saturates the count, then random paths.
// A clocked driver feeds them with bursty gaps, a clocked
// monitor takes results with bursty stalls, and a behavioral shoelace and
// square-root predictor supplies the expected area, length and count.
// ----------------------------------------------------------------------------
module polyline_area_and_length_test;
    import pal_pkg::*;

    localparam int    RANDOM_BEATS = 500;
    localparam int    LONG_PATH    = 1100;
    localparam int    CALM_TAIL    = 150;
    localparam int    QUIET_LIMIT  = 4000;
    localparam int    DRAIN_CYCLES = 64;
    localparam longint AREA_HI     = (longint'(1) << (AREA_W - 1)) - 1;
    localparam longint AREA_LO     = -(longint'(1) << (AREA_W - 1));
    localparam longint AREA_OUT_HI = (longint'(1) << AREA_OUT_W) - 1;
    localparam longint LEN_HI      = (longint'(1) << LEN_W) - 1;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } t_vertex;

    typedef struct {
        logic [AREA_OUT_W-1:0] area;
        logic [LEN_W-1:0]      len;
        logic [CNT_W-1:0]      count;
    } t_path_summary;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // vertex channel
    logic                         vtx_valid = 1'b0;
    logic signed [COORD_BITS-1:0] vtx_x     = '0;
    logic signed [COORD_BITS-1:0] vtx_y     = '0;
    logic                         vtx_last  = 1'b0;
    logic                         vtx_stall;

    // result channel
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [AREA_OUT_W-1:0] res_area;
    logic [LEN_W-1:0]      res_len;
    logic [CNT_W-1:0]      res_count;

    t_vertex       pending_vertices[$];
    t_path_summary summary_q[$];
    t_vertex       next_vertex;
    t_path_summary seen_summary;

    // predictor state for the path in progress
    logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
    logic signed [AREA_W-1:0]     shoelace_acc;
    logic [LEN_W-1:0]             length_acc;
    logic [CNT_W-1:0]             vertices_seen;

    int errors        = 0;
    int beats_in      = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int send_idle_pct = 0;
    int take_stall_pct = 0;
    int quiet_cycles  = 0;
    int random_beats;
    int path_len;
    int coord_mode;

    polyline_area_and_length uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (vtx_valid),
        .o_stall       (vtx_stall),
        .i_x           (vtx_x),
        .i_y           (vtx_y),
        .i_last        (vtx_last),
        .o_valid       (res_valid),
        .i_stall       (res_stall),
        .o_area_q1     (res_area),
        .o_length_q4   (res_len),
        .o_point_count (res_count)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // twice-area accumulate, clamped to the signed range
    function automatic logic signed [AREA_W-1:0] shoelace_add(
        input logic signed [AREA_W-1:0] acc,
        input longint                   term
    );
        longint s;
        s = longint'(acc) + term;
        if (s > AREA_HI) s = AREA_HI;
        else if (s < AREA_LO) s = AREA_LO;
        return s[AREA_W-1:0];
    endfunction

    // floor of the segment length scaled by 2^LENGTH_FRAC_BITS
    function automatic logic [LEN_W-1:0] segment_q4(input longint dx, input longint dy);
        longint radicand, root, trial;
        radicand = (dx * dx + dy * dy) << (2 * LENGTH_FRAC_BITS);
        root = 0;
        for (int b = 26; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= radicand) root = trial;
        end
        return root[LEN_W-1:0];
    endfunction

    function automatic void clear_path();
        first_x       = '0;
        first_y       = '0;
        prev_x        = '0;
        prev_y        = '0;
        shoelace_acc  = '0;
        length_acc    = '0;
        vertices_seen = '0;
    endfunction

    // fold one accepted vertex into the path, queue a summary on the last one
    function automatic void take_vertex(input t_vertex v);
        longint        sum, mag;
        t_path_summary s;
        if (vertices_seen == 0) begin
            first_x = v.x;
            first_y = v.y;
        end else begin
            shoelace_acc = shoelace_add(shoelace_acc,
                (longint'(prev_x) + longint'(v.x)) * (longint'(prev_y) - longint'(v.y)));
            sum = longint'(length_acc) +
                  longint'(segment_q4(longint'(v.x) - longint'(prev_x),
                                      longint'(v.y) - longint'(prev_y)));
            length_acc = (sum > LEN_HI) ? LEN_HI[LEN_W-1:0] : sum[LEN_W-1:0];
        end
        prev_x = v.x;
        prev_y = v.y;
        if (vertices_seen < MAX_POINTS) vertices_seen = vertices_seen + 1'b1;
        if (v.last) begin
            // closing edge back to the first vertex
            shoelace_acc = shoelace_add(shoelace_acc,
                (longint'(v.x) + longint'(first_x)) * (longint'(v.y) - longint'(first_y)));
            mag = (shoelace_acc < 0) ? -longint'(shoelace_acc) : longint'(shoelace_acc);
            s.area  = (mag > AREA_OUT_HI) ? AREA_OUT_HI[AREA_OUT_W-1:0] : mag[AREA_OUT_W-1:0];
            s.len   = length_acc;
            s.count = vertices_seen;
            summary_q.insert(summary_q.size(), s);
            clear_path();
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic void add_vertex(input int x, input int y, input bit last);
        t_vertex v;
        v.x    = x[COORD_BITS-1:0];
        v.y    = y[COORD_BITS-1:0];
        v.last = last;
        pending_vertices.insert(pending_vertices.size(), v);
    endfunction

    // coordinate flavor: full range, near origin, corners and edges
    function automatic int pick_coord(input int mode);
        int c;
        case (mode)
            0: c = int'($urandom_range(0, 127)) - 64;
            1: begin
                case ($urandom_range(0, 3))
                    0: c = -32768;
                    1: c = 32767;
                    2: c = 0;
                    default: c = -1;
                endcase
            end
            default: c = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // clock, reset, run control
    // ------------------------------------------------------------------
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        clear_path();

        // single point paths, at the origin and at a corner
        add_vertex(0, 0, 1'b1);
        add_vertex(-32768, 32767, 1'b1);
        // full diagonal out and back: zero area, longest segment
        add_vertex(-32768, -32768, 1'b0);
        add_vertex(32767, 32767, 1'b1);
        // widest triangle, counterclockwise
        add_vertex(-32768, -32768, 1'b0);
        add_vertex(32767, -32768, 1'b0);
        add_vertex(32767, 32767, 1'b1);
        // widest square, clockwise
        add_vertex(-32768, -32768, 1'b0);
        add_vertex(-32768, 32767, 1'b0);
        add_vertex(32767, 32767, 1'b0);
        add_vertex(32767, -32768, 1'b1);
        // repeated vertex, zero length segment
        add_vertex(5, 5, 1'b0);
        add_vertex(5, 5, 1'b1);
        // small triangle with odd twice-area
        add_vertex(0, 0, 1'b0);
        add_vertex(3, 0, 1'b0);
        add_vertex(0, 1, 1'b1);
        // 3-4-5 segment, exact length
        add_vertex(-1, -2, 1'b0);
        add_vertex(2, 2, 1'b1);

        // long zigzag: count saturates
        for (int i = 0; i < LONG_PATH; i++) begin
            if (i % 2 == 0) add_vertex(-32768, -32768, i == LONG_PATH - 1);
            else add_vertex(32767, 32767, i == LONG_PATH - 1);
        end

        // random paths, mostly short
        random_beats = 0;
        while (random_beats < RANDOM_BEATS) begin
            case ($urandom_range(0, 19))
                0, 1, 2: path_len = 1;
                3, 4:    path_len = $urandom_range(9, 40);
                5:       path_len = $urandom_range(41, 120);
                default: path_len = $urandom_range(2, 8);
            endcase
            coord_mode = $urandom_range(0, 3);
            for (int i = 0; i < path_len; i++) begin
                add_vertex(pick_coord(coord_mode), pick_coord(coord_mode), i == path_len - 1);
            end
            random_beats += path_len;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all beats sent and every summary seen
        @(negedge i_clk);
        while (pending_vertices.size() != 0 || vtx_valid || summary_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // vertex driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vtx_valid <= 1'b0;
        end else begin
            // beat taken at this edge
            if (vtx_valid && !vtx_stall) begin
                next_vertex.x    = vtx_x;
                next_vertex.y    = vtx_y;
                next_vertex.last = vtx_last;
                take_vertex(next_vertex);
                beats_in++;
                if (beats_in % 64 == 0) begin
                    case ($urandom_range(0, 2))
                        0: send_idle_pct = 0;
                        1: send_idle_pct = 10;
                        default: send_idle_pct = 30;
                    endcase
                end
            end
            // present the next beat or idle
            if (!vtx_valid || !vtx_stall) begin
                if (gap_left > 0) begin
                    gap_left  <= gap_left - 1;
                    vtx_valid <= 1'b0;
                end else if (pending_vertices.size() != 0) begin
                    next_vertex = pending_vertices.pop_front();
                    vtx_valid <= 1'b1;
                    vtx_x     <= next_vertex.x;
                    vtx_y     <= next_vertex.y;
                    vtx_last  <= next_vertex.last;
                    if (pending_vertices.size() > CALM_TAIL &&
                        $urandom_range(0, 99) < send_idle_pct) begin
                        gap_left <= $urandom_range(1, 16);
                    end
                end else begin
                    vtx_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_stall <= 1'b0;
        end else begin
            // compare a taken result with the oldest expected summary
            if (res_valid && !res_stall) begin
                if (summary_q.size() == 0) begin
                    $display("%0t: unexpected result area %0d length %0d count %0d",
                             $time, res_area, res_len, res_count);
                    errors++;
                end else begin
                    seen_summary = summary_q.pop_front();
                    if (res_area !== seen_summary.area) begin
                        $display("%0t: area_q1 expected %0d, got %0d",
                                 $time, seen_summary.area, res_area);
                        errors++;
                    end
                    if (res_len !== seen_summary.len) begin
                        $display("%0t: length_q4 expected %0d, got %0d",
                                 $time, seen_summary.len, res_len);
                        errors++;
                    end
                    if (res_count !== seen_summary.count) begin
                        $display("%0t: point_count expected %0d, got %0d",
                                 $time, seen_summary.count, res_count);
                        errors++;
                    end
                end
                case ($urandom_range(0, 2))
                    0: take_stall_pct = 0;
                    1: take_stall_pct = 8;
                    default: take_stall_pct = 25;
                endcase
            end
            // stall bursts, none near the end of the run
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                res_stall  <= 1'b1;
            end else if (pending_vertices.size() > CALM_TAIL &&
                         $urandom_range(0, 99) < take_stall_pct) begin
                stall_left <= $urandom_range(0, 15);
                res_stall  <= 1'b1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog on handshake progress
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((vtx_valid && !vtx_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

endmodule
